// File: rtl/salru_pkg.sv
// Shared constants, types and codes for the set-associative LRU tag tracker.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package salru_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;

    localparam int SETS    = 1 << MAX_SET_BITS;
    localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NODES   = 1 << WAY_W;
    localparam int ADDR_W  = 64;
    localparam int TAG_W   = 64;
    localparam int STAMP_W = 64;
    localparam int CNT_W   = 32;
    // Wide enough for block_bits plus the largest set field.
    localparam int SHIFT_W = 7;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    // Only the modify code changes behavior; every other code is one lookup.
    localparam logic [1:0] KIND_MODIFY = 2'd2;

    typedef struct packed {
        logic               valid;
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_line;

    typedef t_line [MAX_WAYS-1:0] t_row;

    typedef struct packed {
        logic accept;
        logic compare;
        logic reduce;
        logic write;
    } t_cmd;

    typedef struct packed {
        logic skip_reduce;
    } t_stat;

endpackage

// File: rtl/salru_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/salru_ctrl.sv
// Sequencer for one request: lookup, LRU reduction levels, write back.
// Depends on salru_pkg for the command and status structs.
module salru_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    output logic            o_valid,
    input  salru_pkg::t_stat i_stat,
    output salru_pkg::t_cmd  o_cmd
);
    import salru_pkg::*;

    localparam int LVL_W = (WAY_W > 1) ? $clog2(WAY_W) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COMPARE,
        S_REDUCE,
        S_WRITE
    } t_state;

    t_state           r_state;
    logic             r_busy;
    logic             r_done;
    logic [LVL_W-1:0] r_level;

    always_comb begin
        o_cmd.accept  = (r_state == S_IDLE) && start;
        o_cmd.compare = (r_state == S_COMPARE);
        o_cmd.reduce  = (r_state == S_REDUCE);
        o_cmd.write   = (r_state == S_WRITE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_level <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_COMPARE;
                        r_busy  <= 1'b1;
                    end
                end
                S_COMPARE: begin
                    r_level <= '0;
                    // A hit or a free way needs no search for the oldest stamp.
                    if (i_stat.skip_reduce) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_state <= S_REDUCE;
                    end
                end
                S_REDUCE: begin
                    if (r_level == LVL_W'(WAY_W - 1)) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_level <= r_level + 1'b1;
                    end
                end
                S_WRITE: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign busy    = r_busy;
    assign o_valid = r_done;

endmodule

// File: rtl/salru_dp.sv
// Datapath: configuration registers, address split, set RAM, way compare,
// registered LRU tree, write back, access stamp and counters.
// Depends on salru_pkg and salru_ram.
module salru_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  salru_pkg::t_cmd                 i_cmd,
    output salru_pkg::t_stat                o_stat,
    input  logic                            i_cfg_we,
    input  logic [salru_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [salru_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [1:0]                      i_access_kind,
    input  logic [salru_pkg::ADDR_W-1:0]    i_address,
    output logic                            o_first_hit,
    output logic                            o_evicted,
    output logic                            o_second_hit,
    output logic [salru_pkg::CNT_W-1:0]     o_hit_count,
    output logic [salru_pkg::CNT_W-1:0]     o_miss_count,
    output logic [salru_pkg::CNT_W-1:0]     o_eviction_count
);
    import salru_pkg::*;

    typedef struct packed {
        logic               present;
        logic [WAY_W-1:0]   idx;
        logic [STAMP_W-1:0] stamp;
    } t_node;

    // Ties go to the left input, which always holds the lower way number.
    function automatic t_node pick_older(t_node a, t_node b);
        t_node res;
        if (a.present && b.present) begin
            res = (a.stamp <= b.stamp) ? a : b;
        end else if (a.present) begin
            res = a;
        end else begin
            res = b;
        end
        return res;
    endfunction

    // Configuration.
    logic [2:0] r_set_bits;
    logic [5:0] r_block_bits;
    logic [3:0] r_ways;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= '0;
            r_block_bits <= '0;
            r_ways       <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SET_BITS:    r_set_bits   <= i_cfg_data[2:0];
                CFG_BLOCK_BITS:  r_block_bits <= i_cfg_data[5:0];
                CFG_WAYS_IN_USE: r_ways       <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Address split.
    logic [SHIFT_W-1:0] sb_eff;
    logic [SHIFT_W-1:0] shift;
    logic [TAG_W-1:0]   tag_in;
    logic [ADDR_W-1:0]  blk_shifted;
    logic [SET_W-1:0]   set_in;

    always_comb begin
        sb_eff = (32'(r_set_bits) > MAX_SET_BITS) ? SHIFT_W'(MAX_SET_BITS)
                                                  : SHIFT_W'(r_set_bits);
        shift  = SHIFT_W'(r_block_bits) + sb_eff;
        tag_in = (shift >= SHIFT_W'(64)) ? '0 : TAG_W'(i_address >> shift);
        blk_shifted = i_address >> r_block_bits;
        for (int j = 0; j < SET_W; j++) begin
            set_in[j] = blk_shifted[j] && (SHIFT_W'(j) < sb_eff);
        end
    end

    logic [TAG_W-1:0] r_tag;
    logic [SET_W-1:0] r_set;
    logic             r_modify;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tag    <= tag_in;
            r_set    <= set_in;
            r_modify <= (i_access_kind == KIND_MODIFY);
        end
    end

    // Set memory: one row holds every way of a set.
    t_row ram_rdata;
    t_row row_next;

    salru_ram #(
        .WIDTH ($bits(t_row)),
        .DEPTH (SETS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.write),
        .i_waddr (r_set),
        .i_wdata (row_next),
        .i_re    (i_cmd.accept),
        .i_raddr (set_in),
        .o_rdata (ram_rdata)
    );

    // A row that was never written since reset reads as all ways invalid.
    logic [SETS-1:0] r_row_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (i_cmd.write) begin
            r_row_valid[r_set] <= 1'b1;
        end
    end

    // Lookup over all ways in parallel.
    t_row             row_eff;
    logic [MAX_WAYS-1:0] used;
    logic             hit_any;
    logic [WAY_W-1:0] hit_idx;
    logic             inv_any;
    logic [WAY_W-1:0] inv_idx;

    always_comb begin
        row_eff = ram_rdata;
        hit_any = 1'b0;
        hit_idx = '0;
        inv_any = 1'b0;
        inv_idx = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            row_eff[w].valid = ram_rdata[w].valid && r_row_valid[r_set];
            used[w] = (w == 0) || (32'(r_ways) > w);
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (used[w] && row_eff[w].valid && (row_eff[w].tag == r_tag)) begin
                hit_any = 1'b1;
                hit_idx = WAY_W'(w);
            end
            if (used[w] && !row_eff[w].valid) begin
                inv_any = 1'b1;
                inv_idx = WAY_W'(w);
            end
        end
    end

    assign o_stat.skip_reduce = hit_any || inv_any;

    t_row             r_row;
    logic             r_hit;
    logic [WAY_W-1:0] r_hit_idx;
    logic             r_has_inv;
    logic [WAY_W-1:0] r_inv_idx;
    t_node            r_node [NODES];
    t_node            n_node [NODES];

    always_comb begin
        for (int i = 0; i < NODES; i++) begin
            n_node[i] = '0;
        end
        if (i_cmd.compare) begin
            for (int i = 0; i < NODES; i++) begin
                if (i < MAX_WAYS) begin
                    n_node[i].present = used[i];
                    n_node[i].idx     = WAY_W'(i);
                    n_node[i].stamp   = row_eff[i].stamp;
                end
            end
        end else begin
            for (int i = 0; i < NODES / 2; i++) begin
                n_node[i] = pick_older(r_node[2 * i], r_node[2 * i + 1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.compare) begin
            r_row     <= row_eff;
            r_hit     <= hit_any;
            r_hit_idx <= hit_idx;
            r_has_inv <= inv_any;
            r_inv_idx <= inv_idx;
        end
        if (i_cmd.compare || i_cmd.reduce) begin
            r_node <= n_node;
        end
    end

    // Write back and bookkeeping.
    logic [STAMP_W-1:0] r_stamp;
    logic [CNT_W-1:0]   r_hits;
    logic [CNT_W-1:0]   r_misses;
    logic [CNT_W-1:0]   r_evicts;
    logic               r_first_hit;
    logic               r_evicted;
    logic               r_second_hit;
    logic [WAY_W-1:0]   way_sel;
    logic               evict_now;

    always_comb begin
        priority if (r_hit) begin
            way_sel   = r_hit_idx;
            evict_now = 1'b0;
        end else if (r_has_inv) begin
            way_sel   = r_inv_idx;
            evict_now = 1'b0;
        end else begin
            way_sel   = r_node[0].idx;
            evict_now = 1'b1;
        end
        row_next = r_row;
        row_next[way_sel].valid = 1'b1;
        row_next[way_sel].tag   = r_tag;
        row_next[way_sel].stamp = r_stamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stamp  <= '0;
            r_hits   <= '0;
            r_misses <= '0;
            r_evicts <= '0;
        end else if (i_cmd.write) begin
            r_stamp <= r_stamp + 1'b1;
            // The store half of a modify always finds the line just touched.
            r_hits   <= r_hits + CNT_W'(r_hit) + CNT_W'(r_modify);
            r_misses <= r_misses + CNT_W'(!r_hit);
            r_evicts <= r_evicts + CNT_W'(evict_now);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_first_hit  <= r_hit;
            r_evicted    <= evict_now;
            r_second_hit <= r_modify;
        end
    end

    assign o_first_hit      = r_first_hit;
    assign o_evicted        = r_evicted;
    assign o_second_hit     = r_second_hit;
    assign o_hit_count      = r_hits;
    assign o_miss_count     = r_misses;
    assign o_eviction_count = r_evicts;

endmodule

// File: rtl/set_assoc_cache_lru_tracker_core.sv
// Top level of the set-associative LRU tag tracker.
// Depends on salru_pkg, salru_ctrl and salru_dp (which holds salru_ram).
//
// Usage:
//   A request (access kind and 64-bit address) is taken at a rising edge
//   where start is high and busy is low. busy then stays high until the
//   request is written back. The result appears on the o_ ports for one
//   cycle with o_valid high; it cannot be held off.
//   Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data;
//   the user must write it only while the block is idle, which the block
//   itself does not enforce. Indexes beyond the list are ignored.
//   A hit or a fill into a free way goes from the compare step straight to
//   write back and is shown in the cycle after that; a new request is taken
//   only once the block is idle again. When the set is full, the oldest
//   stamp is found by a registered tree, one level per cycle, before write
//   back. The set RAM's registered read and single write-back port set this base sequence.
//   Reset clears the stamp, the counters and one valid flag per set, so the
//   tag store reads as empty at once, and returns the configuration to one
//   set, one way and zero block bits; no clearing pass is needed.
module set_assoc_cache_lru_tracker_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [1:0]                      i_access_kind,
    input  logic [salru_pkg::ADDR_W-1:0]    i_address,
    input  logic                            i_cfg_we,
    input  logic [salru_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [salru_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                            o_valid,
    output logic                            o_first_hit,
    output logic                            o_evicted,
    output logic                            o_second_hit,
    output logic [salru_pkg::CNT_W-1:0]     o_hit_count,
    output logic [salru_pkg::CNT_W-1:0]     o_miss_count,
    output logic [salru_pkg::CNT_W-1:0]     o_eviction_count
);
    import salru_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    salru_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    salru_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_access_kind    (i_access_kind),
        .i_address        (i_address),
        .o_first_hit      (o_first_hit),
        .o_evicted        (o_evicted),
        .o_second_hit     (o_second_hit),
        .o_hit_count      (o_hit_count),
        .o_miss_count     (o_miss_count),
        .o_eviction_count (o_eviction_count)
    );

endmodule

// File: rtl/salru_checker.sv
// Port-level checks for the LRU tag tracker, attached by bind.
// Depends on salru_pkg and set_assoc_cache_lru_tracker_core.
module salru_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_valid,
    input logic                        o_first_hit,
    input logic                        o_evicted,
    input logic [salru_pkg::CNT_W-1:0] o_miss_count,
    input logic [salru_pkg::CNT_W-1:0] o_eviction_count
);

    // A taken request keeps the block busy until its result is shown.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after a request was taken");

    // The result is shown once the block is free again, never twice in a row.
    a_valid_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (!busy ##1 !o_valid))
        else $error("result strobe while busy or repeated");

    // A hit never evicts.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_first_hit) |-> !o_evicted)
        else $error("eviction reported on a hit");

    // A miss advances the miss total by exactly one.
    a_miss_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_first_hit) |-> (o_miss_count == $past(o_miss_count) + 1'b1))
        else $error("miss total did not advance by one");

    // An eviction advances the eviction total by exactly one.
    a_evict_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_evicted) |->
            (o_eviction_count == $past(o_eviction_count) + 1'b1))
        else $error("eviction total did not advance by one");

endmodule

bind set_assoc_cache_lru_tracker_core salru_checker u_salru_checker (.*);

// File: tb/lru_tracker_checker.sv
// Checker for the set-associative LRU tag tracker: keeps its own copy of the tag store,
// predicts the outcome of every accepted request and compares it with the block's result.
// Depends on salru_pkg only.
module lru_tracker_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  logic [1:0]                       i_access_kind,
    input  logic [salru_pkg::ADDR_W-1:0]     i_address,
    input  logic                             i_cfg_we,
    input  logic [salru_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [salru_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_valid,
    input  logic                             i_first_hit,
    input  logic                             i_evicted,
    input  logic                             i_second_hit,
    input  logic [salru_pkg::CNT_W-1:0]      i_hit_count,
    input  logic [salru_pkg::CNT_W-1:0]      i_miss_count,
    input  logic [salru_pkg::CNT_W-1:0]      i_eviction_count,
    output int                               o_mismatches,
    output int                               o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import salru_pkg::*;

    localparam int ENTRIES = SETS * MAX_WAYS;

    typedef struct packed {
        logic             first_hit;
        logic             evicted;
        logic             second_hit;
        logic [CNT_W-1:0] hits;
        logic [CNT_W-1:0] misses;
        logic [CNT_W-1:0] evictions;
    } t_outcome;

    logic               way_valid [ENTRIES];
    logic [TAG_W-1:0]   way_tag   [ENTRIES];
    logic [STAMP_W-1:0] way_age   [ENTRIES];
    logic [STAMP_W-1:0] now_stamp;
    logic [CNT_W-1:0]   hit_tally;
    logic [CNT_W-1:0]   miss_tally;
    logic [CNT_W-1:0]   evict_tally;
    logic [2:0]         cfg_set_bits;
    logic [5:0]         cfg_block_bits;
    logic [3:0]         cfg_ways;

    t_outcome outcome_q[$];
    t_outcome next_outcome;
    t_outcome observed;
    int       fail_count = 0;
    int       pending    = 0;

    assign o_mismatches  = fail_count;
    assign o_outstanding = pending;

    // One lookup in the set whose first entry is base. A miss fills the first
    // free way, or else replaces the least recently used one.
    task automatic probe_set(input int unsigned base, input int unsigned ways,
                             input logic [TAG_W-1:0] tag,
                             output logic hit, output logic replaced);
        int unsigned        w;
        int unsigned        pick;
        logic               found_free;
        logic               have_old;
        logic [STAMP_W-1:0] oldest;
        hit        = 1'b0;
        replaced   = 1'b0;
        pick       = 0;
        found_free = 1'b0;
        have_old   = 1'b0;
        oldest     = '0;
        for (w = 0; w < ways; w++) begin
            if (!hit && way_valid[base+w] && way_tag[base+w] == tag) begin
                hit = 1'b1;
                way_age[base+w] = now_stamp;
            end
        end
        if (hit) begin
            hit_tally = hit_tally + 1'b1;
        end else begin
            miss_tally = miss_tally + 1'b1;
            for (w = 0; w < ways; w++) begin
                if (!found_free) begin
                    if (!way_valid[base+w]) begin
                        pick       = w;
                        found_free = 1'b1;
                    end else if (!have_old || way_age[base+w] < oldest) begin
                        oldest   = way_age[base+w];
                        pick     = w;
                        have_old = 1'b1;
                    end
                end
            end
            if (way_valid[base+pick]) begin
                evict_tally = evict_tally + 1'b1;
                replaced    = 1'b1;
            end
            way_valid[base+pick] = 1'b1;
            way_tag[base+pick]   = tag;
            way_age[base+pick]   = now_stamp;
        end
    endtask

    task automatic predict_request(input logic [1:0] kind, input logic [ADDR_W-1:0] addr,
                                   output t_outcome res);
        int unsigned       sb;
        int unsigned       ways;
        int unsigned       shift;
        int unsigned       base;
        logic [TAG_W-1:0]  tag;
        logic [ADDR_W-1:0] set_sel;
        logic              first;
        logic              replaced;
        logic              second;
        logic              unused_replaced;
        sb    = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set_bits;
        ways  = (cfg_ways == 0) ? 1 : (cfg_ways > MAX_WAYS) ? MAX_WAYS : cfg_ways;
        shift = sb + cfg_block_bits;
        tag   = (shift >= TAG_W) ? '0 : (addr >> shift);
        set_sel = (addr >> cfg_block_bits) & ((64'd1 << sb) - 64'd1);
        base  = set_sel[SET_W-1:0] * MAX_WAYS;
        probe_set(base, ways, tag, first, replaced);
        second = 1'b0;
        // The store half of a modify finds the line that the load half left.
        if (kind == KIND_MODIFY) begin
            probe_set(base, ways, tag, second, unused_replaced);
        end
        now_stamp = now_stamp + 1'b1;
        res = '{first, replaced, second, hit_tally, miss_tally, evict_tally};
    endtask

    task automatic note_failure(input string what, input t_outcome exp, input t_outcome got);
        fail_count++;
        if (fail_count <= 10) begin
            $display("MISMATCH %s at %0t: expected first_hit=%0b evicted=%0b second_hit=%0b",
                     what, $realtime, exp.first_hit, exp.evicted, exp.second_hit);
            $display("    hits=%0d misses=%0d evictions=%0d; got first_hit=%0b evicted=%0b",
                     exp.hits, exp.misses, exp.evictions, got.first_hit, got.evicted);
            $display("    second_hit=%0b hits=%0d misses=%0d evictions=%0d",
                     got.second_hit, got.hits, got.misses, got.evictions);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < ENTRIES; e++) begin
                way_valid[e] = 1'b0;
                way_tag[e]   = '0;
                way_age[e]   = '0;
            end
            now_stamp      = '0;
            hit_tally      = '0;
            miss_tally     = '0;
            evict_tally    = '0;
            cfg_set_bits   = '0;
            cfg_block_bits = '0;
            cfg_ways       = 4'd1;
            outcome_q.delete();
        end else begin
            // Results are checked before new requests are queued, so a result
            // can never be matched against the request taken at the same edge.
            if (i_valid) begin
                observed = '{i_first_hit, i_evicted, i_second_hit,
                             i_hit_count, i_miss_count, i_eviction_count};
                if (outcome_q.size() == 0) begin
                    note_failure("result with no request outstanding", '0, observed);
                end else begin
                    next_outcome = outcome_q.pop_front();
                    if (observed.first_hit  !== next_outcome.first_hit  ||
                        observed.evicted    !== next_outcome.evicted    ||
                        observed.second_hit !== next_outcome.second_hit ||
                        observed.hits       !== next_outcome.hits       ||
                        observed.misses     !== next_outcome.misses     ||
                        observed.evictions  !== next_outcome.evictions) begin
                        note_failure("wrong result", next_outcome, observed);
                    end
                end
            end
            if (i_start && !i_busy) begin
                predict_request(i_access_kind, i_address, next_outcome);
                outcome_q.push_back(next_outcome);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SET_BITS:    cfg_set_bits   = i_cfg_data[2:0];
                    CFG_BLOCK_BITS:  cfg_block_bits = i_cfg_data[5:0];
                    CFG_WAYS_IN_USE: cfg_ways       = i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
        pending = outcome_q.size();
    end

endmodule

// File: tb/tb_set_assoc_cache_lru_tracker_core.sv
// Testbench top for the set-associative LRU tag tracker: drives requests and register writes.
// Depends on salru_pkg, set_assoc_cache_lru_tracker_core and lru_tracker_checker.
module tb_set_assoc_cache_lru_tracker_core;
    timeunit 1ns;
    timeprecision 1ps;
    import salru_pkg::*;

    localparam logic [1:0]           KIND_LOAD  = 2'd0;
    localparam logic [1:0]           KIND_STORE = 2'd1;
    localparam logic [1:0]           KIND_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 9;
    localparam int PHASE_ITEMS  = 150;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  start          = 1'b0;
    logic                  busy;
    logic [1:0]            i_access_kind  = '0;
    logic [ADDR_W-1:0]     i_address      = '0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  o_valid;
    logic                  o_first_hit;
    logic                  o_evicted;
    logic                  o_second_hit;
    logic [CNT_W-1:0]      o_hit_count;
    logic [CNT_W-1:0]      o_miss_count;
    logic [CNT_W-1:0]      o_eviction_count;
    int                    mismatches;
    int                    outstanding;

    // Geometry of each random phase: set bits, block bits, ways in use.
    int phase_sb   [PHASES] = '{1, 2, 0, 6, 7, 3, 4, 5, 2};
    int phase_bb   [PHASES] = '{4, 0, 63, 58, 6, 12, 1, 60, 32};
    int phase_ways [PHASES] = '{4, 2, 8, 15, 0, 9, 3, 7, 5};

    int                cur_sb;
    int                cur_bb;
    int                cur_ways;
    int                sent   = 0;
    int                cycles = 0;
    int                ph;
    int                k;
    int unsigned       ew;
    logic [ADDR_W-1:0] addr;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    set_assoc_cache_lru_tracker_core uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_access_kind    (i_access_kind),
        .i_address        (i_address),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_valid          (o_valid),
        .o_first_hit      (o_first_hit),
        .o_evicted        (o_evicted),
        .o_second_hit     (o_second_hit),
        .o_hit_count      (o_hit_count),
        .o_miss_count     (o_miss_count),
        .o_eviction_count (o_eviction_count)
    );

    lru_tracker_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (start),
        .i_busy           (busy),
        .i_access_kind    (i_access_kind),
        .i_address        (i_address),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (o_valid),
        .i_first_hit      (o_first_hit),
        .i_evicted        (o_evicted),
        .i_second_hit     (o_second_hit),
        .i_hit_count      (o_hit_count),
        .i_miss_count     (o_miss_count),
        .i_eviction_count (o_eviction_count),
        .o_mismatches     (mismatches),
        .o_outstanding    (outstanding)
    );

    // Builds an address for the current geometry from a tag and a set, with a
    // random block offset.
    function automatic logic [ADDR_W-1:0] place(input logic [ADDR_W-1:0] tag_part,
                                                input int unsigned set_part);
        int unsigned       sb;
        logic [ADDR_W-1:0] low_mask;
        logic [ADDR_W-1:0] set_field;
        sb        = (cur_sb > MAX_SET_BITS) ? MAX_SET_BITS : cur_sb;
        low_mask  = (64'd1 << cur_bb) - 64'd1;
        set_field = 64'(set_part) & ((64'd1 << sb) - 64'd1);
        return (tag_part << (sb + cur_bb)) | (set_field << cur_bb)
               | ({$urandom, $urandom} & low_mask);
    endfunction

    // Called at a falling edge; returns at the falling edge after the request
    // has been taken. Each cycle the sender idles with odds set by how many requests were sent.
    task automatic issue(input logic [1:0] kind, input logic [ADDR_W-1:0] where);
        int pct;
        pct = (sent < 450) ? 27 : (sent < 900) ? 73 : 0;
        while ($urandom_range(99) < pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start         <= 1'b1;
        i_access_kind <= kind;
        i_address     <= where;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
        sent++;
    endtask

    // Registers are only written once every result has come back. The unused
    // index is written too, and the data bits above the set-bits and ways registers are random.
    task automatic set_geometry(input int sb, input int bb, input int ways);
        start <= 1'b0;
        while (outstanding != 0 || busy) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_SET_BITS;
        i_cfg_data <= {3'($urandom), 3'(sb)};
        @(negedge i_clk);
        i_cfg_idx  <= CFG_BLOCK_BITS;
        i_cfg_data <= 6'(bb);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_WAYS_IN_USE;
        i_cfg_data <= {2'($urandom), 4'(ways)};
        @(negedge i_clk);
        i_cfg_idx  <= CFG_UNUSED;
        i_cfg_data <= 6'($urandom);
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        cur_sb   = sb;
        cur_bb   = bb;
        cur_ways = ways;
    endtask

    initial begin
        cur_sb   = 0;
        cur_bb   = 0;
        cur_ways = 1;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset geometry: one set, one way, so every new tag replaces the line.
        issue(KIND_LOAD, '0);
        issue(KIND_LOAD, '0);
        issue(KIND_STORE, '1);
        issue(KIND_MODIFY, '1);
        issue(KIND_SPARE, '0);
        issue(KIND_MODIFY, 64'h5555_5555_5555_5555);

        // Fill a four-way set, touch the first line, then force a replacement
        // of the least recently used one.
        set_geometry(2, 4, 4);
        for (k = 1; k <= 4; k++) begin
            issue(KIND_STORE, place(64'(k), 1));
        end
        issue(KIND_LOAD, place(64'd1, 1));
        issue(KIND_MODIFY, place(64'd5, 1));

        // Set bits above the built maximum and a shift that leaves no tag bits.
        set_geometry(7, 58, 15);
        issue(KIND_LOAD, 64'hAAAA_AAAA_AAAA_AAAA);
        issue(KIND_LOAD, 64'h5555_5555_5555_5555);
        issue(KIND_MODIFY, 64'hFC00_0000_0000_0000);

        // Widest block field, and a ways register of zero acting as one way.
        set_geometry(3, 63, 0);
        issue(KIND_LOAD, 64'h8000_0000_0000_0000);
        issue(KIND_STORE, '0);
        issue(KIND_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);

        // Mostly small tag pools over a few sets so lines hit, fill and age out;
        // the rest are unrelated full-width addresses.
        for (ph = 0; ph < PHASES; ph++) begin
            set_geometry(phase_sb[ph], phase_bb[ph], phase_ways[ph]);
            ew = (cur_ways == 0) ? 1 : (cur_ways > MAX_WAYS) ? MAX_WAYS : cur_ways;
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(99) < 80) begin
                    addr = place(64'($urandom_range(0, ew + 2)), $urandom_range(0, 3));
                end else begin
                    addr = {$urandom, $urandom};
                end
                issue(2'($urandom_range(0, 3)), addr);
            end
        end

        start <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
